// File: design/dmx_pkg.sv
// Shared types and constants for the surround-to-stereo downmix block.
package dmx_pkg;

  localparam int NUM_CHAN   = 8;
  localparam int WORD_W     = 24;
  localparam int SAMP_W     = 16;
  localparam int PRE_W      = 32;
  localparam int GAIN_W     = 16;
  localparam int PROD_W     = PRE_W + GAIN_W + 1;
  localparam int MIX_SHIFT  = 27;
  localparam int COPY_SHIFT = 15;

  // Q15 mix coefficients: 0.2929 on front and back, 0.2071 on center and LFE.
  localparam logic [14:0] COEF_FB = 15'd9598;
  localparam logic [14:0] COEF_CL = 15'd6786;

  // Word format codes; the unused code behaves as 16-bit signed.
  localparam logic [1:0] MODE_U8  = 2'd0;
  localparam logic [1:0] MODE_S16 = 2'd1;
  localparam logic [1:0] MODE_S24 = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IDX_MODE  = 2'd0;
  localparam logic [1:0] CFG_IDX_COUNT = 2'd1;
  localparam logic [1:0] CFG_IDX_GAIN  = 2'd2;

  localparam logic [1:0]  RST_MODE  = MODE_S16;
  localparam logic [3:0]  RST_COUNT = 4'd2;
  localparam logic [15:0] RST_GAIN  = 16'd4096;

  typedef struct packed {
    logic signed [SAMP_W-1:0] samp;
    logic [SAMP_W-1:0]        mag;
  } lane_t;

  typedef struct packed {
    logic signed [PRE_W-1:0] pre_l;
    logic signed [PRE_W-1:0] pre_r;
    logic [SAMP_W-1:0]       peak;
    logic                    last;
  } mix_t;

endpackage

// File: design/surround_to_stereo_downmix_gain_top.sv
// Top level of the surround-to-stereo downmix with gain and buffer peak tracking.
// One frame of up to eight channel words goes in per item and one stereo result
// comes out. Eight lanes normalize the channels side by side as the frame is
// taken; a merge stage then forms the peak and the coefficient products, a
// second merge stage the stereo sums, and the gain unit multiplies and then
// truncates and saturates into the output register. An item moves from the lane
// registers through the product, sum and gain product registers to the output
// register, and a new frame is taken in the cycle after the previous one has
// reached it, so only one frame is in flight at a time. The running peak is
// cleared after a frame marked as the end of a buffer. Configuration registers
// may be written at any time the block is idle; the write port is always ready.
module surround_to_stereo_downmix_gain_top
  import dmx_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [WORD_W-1:0]        in_chan0_word,
  input  logic [WORD_W-1:0]        in_chan1_word,
  input  logic [WORD_W-1:0]        in_chan2_word,
  input  logic [WORD_W-1:0]        in_chan3_word,
  input  logic [WORD_W-1:0]        in_chan4_word,
  input  logic [WORD_W-1:0]        in_chan5_word,
  input  logic [WORD_W-1:0]        in_chan6_word,
  input  logic [WORD_W-1:0]        in_chan7_word,
  input  logic                     in_buffer_end,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [SAMP_W-1:0] out_left_out,
  output logic signed [SAMP_W-1:0] out_right_out,
  output logic [SAMP_W-1:0]        out_buffer_peak,
  output logic                     out_peak_final,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_data
);

  localparam logic [3:0] MAX_CNT = 4'(MAX_CHANNELS);

  logic [1:0]        cfg_mode_r;
  logic [3:0]        cfg_count_r;
  logic [GAIN_W-1:0] cfg_gain_r;
  logic [3:0]        n_eff;
  logic              in_acc, busy, hold, ld_out;
  logic              v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic              v4_nxt, out_valid_nxt;
  logic [WORD_W-1:0] words [NUM_CHAN];
  lane_t             lane_c [NUM_CHAN];
  lane_t             lane_r [NUM_CHAN];
  logic              last_r, downmix_r, mono_r;
  mix_t              mix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r  <= RST_MODE;
      cfg_count_r <= RST_COUNT;
      cfg_gain_r  <= RST_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_MODE:  cfg_mode_r  <= cfg_data[1:0];
        CFG_IDX_COUNT: cfg_count_r <= cfg_data[3:0];
        CFG_IDX_GAIN:  cfg_gain_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A count of zero means mono; counts above the lane limit are clamped.
  always_comb begin
    priority if (cfg_count_r == 4'd0) begin
      n_eff = 4'd1;
    end else if (cfg_count_r > MAX_CNT) begin
      n_eff = MAX_CNT;
    end else begin
      n_eff = cfg_count_r;
    end
  end

  assign words[0] = in_chan0_word;
  assign words[1] = in_chan1_word;
  assign words[2] = in_chan2_word;
  assign words[3] = in_chan3_word;
  assign words[4] = in_chan4_word;
  assign words[5] = in_chan5_word;
  assign words[6] = in_chan6_word;
  assign words[7] = in_chan7_word;

  for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
    dmx_lane u_lane (
      .word (words[g]),
      .mode (cfg_mode_r),
      .used (4'(g) < n_eff),
      .lane (lane_c[g])
    );
  end

  // Only one item is in flight between acceptance and the output register.
  assign busy     = v1_r | v2_r | v3_r | v4_r;
  assign in_stall = busy;
  assign in_acc   = in_valid & ~in_stall;
  assign hold     = out_valid_r & out_stall;
  assign ld_out   = v4_r & ~hold;
  assign v4_nxt   = v3_r | (v4_r & hold);

  always_comb begin
    if (ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_acc;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v4_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      lane_r    <= lane_c;
      last_r    <= in_buffer_end;
      downmix_r <= (n_eff >= 4'd6);
      mono_r    <= (n_eff == 4'd1);
    end
  end

  dmx_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld_prod (v1_r),
    .ld_sum  (v2_r),
    .lanes   (lane_r),
    .downmix (downmix_r),
    .mono    (mono_r),
    .last    (last_r),
    .mix     (mix)
  );

  dmx_gain u_gain (
    .clk         (clk),
    .ld_mul      (v3_r),
    .ld_out      (ld_out),
    .gain        (cfg_gain_r),
    .mix         (mix),
    .left_out    (out_left_out),
    .right_out   (out_right_out),
    .buffer_peak (out_buffer_peak),
    .peak_final  (out_peak_final)
  );

  assign out_valid = out_valid_r;

endmodule

// File: design/dmx_lane.sv
// One channel lane: normalizes a raw word to a 16-bit sample and its magnitude.
module dmx_lane
  import dmx_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  input  logic [1:0]        mode,
  input  logic              used,
  output lane_t             lane
);

  logic signed [SAMP_W-1:0] samp;
  logic signed [SAMP_W:0]   samp_ext;
  logic [SAMP_W:0]          abs_ext;

  always_comb begin
    unique case (mode)
      // Offset binary byte: flipping the top bit subtracts 128.
      MODE_U8:  samp = {~word[7], word[6:0], 8'h00};
      MODE_S24: samp = word[23:8];
      MODE_S16: samp = word[15:0];
      default:  samp = word[15:0];
    endcase
  end

  assign samp_ext = {samp[SAMP_W-1], samp};
  assign abs_ext  = samp_ext[SAMP_W] ? 17'(-samp_ext) : 17'(samp_ext);

  assign lane.samp = samp;
  // Unused channels contribute nothing to the peak.
  assign lane.mag  = used ? abs_ext[SAMP_W-1:0] : '0;

endmodule

// File: design/dmx_merge.sv
// Merge stages: peak over all lanes, coefficient products and the stereo sums.
module dmx_merge
  import dmx_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  ld_prod,
  input  logic  ld_sum,
  input  lane_t lanes [NUM_CHAN],
  input  logic  downmix,
  input  logic  mono,
  input  logic  last,
  output mix_t  mix
);

  logic signed [PRE_W-1:0]  prod_fl_r, prod_fr_r, prod_c_r;
  logic signed [SAMP_W-1:0] copy_l_r, copy_r_r;
  logic                     downmix_r, last_r;
  logic [SAMP_W-1:0]        peak_r;
  logic [SAMP_W-1:0]        running_peak_r, running_peak_nxt;
  logic [SAMP_W-1:0]        peak_nxt;
  logic signed [SAMP_W:0]   sum_l, sum_r, sum_c;
  mix_t                     mix_r, mix_nxt;

  always_comb begin
    peak_nxt = running_peak_r;
    for (int i = 0; i < NUM_CHAN; i++) begin
      if (lanes[i].mag > peak_nxt) begin
        peak_nxt = lanes[i].mag;
      end
    end
    running_peak_nxt = last ? '0 : peak_nxt;
  end

  assign sum_l = 17'(lanes[0].samp) + 17'(lanes[4].samp);
  assign sum_r = 17'(lanes[1].samp) + 17'(lanes[5].samp);
  assign sum_c = 17'(lanes[2].samp) + 17'(lanes[3].samp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_peak_r <= '0;
    end else if (ld_prod) begin
      running_peak_r <= running_peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_prod) begin
      prod_fl_r <= PRE_W'(sum_l) * $signed(PRE_W'(COEF_FB));
      prod_fr_r <= PRE_W'(sum_r) * $signed(PRE_W'(COEF_FB));
      prod_c_r  <= PRE_W'(sum_c) * $signed(PRE_W'(COEF_CL));
      copy_l_r  <= lanes[0].samp;
      copy_r_r  <= mono ? lanes[0].samp : lanes[1].samp;
      downmix_r <= downmix;
      peak_r    <= peak_nxt;
      last_r    <= last;
    end
  end

  // A copied sample is moved up to Q15 so both paths share one gain shift.
  always_comb begin
    if (downmix_r) begin
      mix_nxt.pre_l = prod_fl_r + prod_c_r;
      mix_nxt.pre_r = prod_fr_r + prod_c_r;
    end else begin
      mix_nxt.pre_l = {copy_l_r[SAMP_W-1], copy_l_r, COPY_SHIFT'(0)};
      mix_nxt.pre_r = {copy_r_r[SAMP_W-1], copy_r_r, COPY_SHIFT'(0)};
    end
    mix_nxt.peak = peak_r;
    mix_nxt.last = last_r;
  end

  always_ff @(posedge clk) begin
    if (ld_sum) begin
      mix_r <= mix_nxt;
    end
  end

  assign mix = mix_r;

endmodule

// File: design/dmx_gain.sv
// Gain stages: multiply by the Q4.12 gain, truncate toward zero and saturate.
module dmx_gain
  import dmx_pkg::*;
(
  input  logic                     clk,
  input  logic                     ld_mul,
  input  logic                     ld_out,
  input  logic [GAIN_W-1:0]        gain,
  input  mix_t                     mix,
  output logic signed [SAMP_W-1:0] left_out,
  output logic signed [SAMP_W-1:0] right_out,
  output logic [SAMP_W-1:0]        buffer_peak,
  output logic                     peak_final
);

  localparam logic signed [PROD_W-1:0] ROUND_ADJ = PROD_W'((64'd1 << MIX_SHIFT) - 64'd1);
  localparam logic signed [PROD_W-1:0] SAT_MAX   = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_MIN   = -PROD_W'(32768);

  logic signed [PROD_W-1:0] prod_l_r, prod_r_r;
  logic [SAMP_W-1:0]        peak_r;
  logic                     last_r;
  logic signed [SAMP_W-1:0] left_r, right_r;
  logic [SAMP_W-1:0]        buffer_peak_r;
  logic                     peak_final_r;
  logic signed [SAMP_W-1:0] left_nxt, right_nxt;
  logic signed [GAIN_W:0]   gain_s;

  assign gain_s = {1'b0, gain};

  function automatic logic signed [SAMP_W-1:0] scale_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] q;
    logic signed [SAMP_W-1:0] res;
    // Biasing negative values makes the arithmetic shift truncate toward zero.
    q = (p[PROD_W-1] ? p + ROUND_ADJ : p) >>> MIX_SHIFT;
    if (q > SAT_MAX) begin
      res = 16'sh7FFF;
    end else if (q < SAT_MIN) begin
      res = 16'sh8000;
    end else begin
      res = q[SAMP_W-1:0];
    end
    return res;
  endfunction

  assign left_nxt  = scale_sat(prod_l_r);
  assign right_nxt = scale_sat(prod_r_r);

  always_ff @(posedge clk) begin
    if (ld_mul) begin
      prod_l_r <= PROD_W'(mix.pre_l) * PROD_W'(gain_s);
      prod_r_r <= PROD_W'(mix.pre_r) * PROD_W'(gain_s);
      peak_r   <= mix.peak;
      last_r   <= mix.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      left_r        <= left_nxt;
      right_r       <= right_nxt;
      buffer_peak_r <= peak_r;
      peak_final_r  <= last_r;
    end
  end

  assign left_out    = left_r;
  assign right_out   = right_r;
  assign buffer_peak = buffer_peak_r;
  assign peak_final  = peak_final_r;

endmodule

// File: sim/downmix_checker.sv
// Checker for the downmix block: predicts each stereo frame and compares the results.
module downmix_checker
  import dmx_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [WORD_W-1:0]        in_chan0_word,
  input  logic [WORD_W-1:0]        in_chan1_word,
  input  logic [WORD_W-1:0]        in_chan2_word,
  input  logic [WORD_W-1:0]        in_chan3_word,
  input  logic [WORD_W-1:0]        in_chan4_word,
  input  logic [WORD_W-1:0]        in_chan5_word,
  input  logic [WORD_W-1:0]        in_chan6_word,
  input  logic [WORD_W-1:0]        in_chan7_word,
  input  logic                     in_buffer_end,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [SAMP_W-1:0] out_left_out,
  input  logic signed [SAMP_W-1:0] out_right_out,
  input  logic [SAMP_W-1:0]        out_buffer_peak,
  input  logic                     out_peak_final,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GAIN_FRAC = 12;

  typedef struct {
    logic signed [SAMP_W-1:0] left;
    logic signed [SAMP_W-1:0] right;
    logic [SAMP_W-1:0]        peak;
    logic                     last;
  } stereo_frame_t;

  logic [1:0]        width_mode;
  logic [3:0]        chan_count;
  logic [GAIN_W-1:0] gain;
  logic [SAMP_W-1:0] running_peak;
  stereo_frame_t     expected_frames[$];
  stereo_frame_t     want;
  int                mismatches;

  function automatic int unpack_sample(input logic [1:0] mode, input logic [WORD_W-1:0] w);
    case (mode)
      MODE_U8:  return (int'(w[7:0]) - 128) * 256;
      MODE_S24: return int'($signed(w[23:8]));
      default:  return int'($signed(w[15:0]));
    endcase
  endfunction

  function automatic logic signed [SAMP_W-1:0] clip16(input longint x);
    if (x > 32767) return 16'sh7FFF;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  // Predicts one frame and advances the running buffer peak.
  function automatic stereo_frame_t mix_frame(input logic [NUM_CHAN-1:0][WORD_W-1:0] words,
                                              input logic last);
    int            samp[NUM_CHAN];
    int            used;
    int            mag;
    int            peak;
    longint        g;
    longint        ml;
    longint        mr;
    longint        l;
    longint        r;
    stereo_frame_t f;
    used = chan_count;
    if (used == 0) used = 1;
    if (used > MAX_CHANNELS) used = MAX_CHANNELS;
    peak = running_peak;
    g = longint'(gain);
    for (int i = 0; i < NUM_CHAN; i++) samp[i] = unpack_sample(width_mode, words[i]);
    for (int i = 0; i < used; i++) begin
      mag = (samp[i] < 0) ? -samp[i] : samp[i];
      if (mag > peak) peak = mag;
    end
    if (used >= 6) begin
      ml = longint'(COEF_FB) * (samp[0] + samp[4]) + longint'(COEF_CL) * (samp[2] + samp[3]);
      mr = longint'(COEF_FB) * (samp[1] + samp[5]) + longint'(COEF_CL) * (samp[2] + samp[3]);
      // Signed division truncates toward zero, as the hardware must.
      l = (ml * g) / (longint'(1) << MIX_SHIFT);
      r = (mr * g) / (longint'(1) << MIX_SHIFT);
    end else begin
      l = (samp[0] * g) / (longint'(1) << GAIN_FRAC);
      r = (used == 1) ? l : (samp[1] * g) / (longint'(1) << GAIN_FRAC);
    end
    f.left = clip16(l);
    f.right = clip16(r);
    f.peak = peak[SAMP_W-1:0];
    f.last = last;
    running_peak = last ? '0 : peak[SAMP_W-1:0];
    return f;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_mode = RST_MODE;
      chan_count = RST_COUNT;
      gain = RST_GAIN;
      running_peak = '0;
      expected_frames.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IDX_MODE:  width_mode = cfg_data[1:0];
          CFG_IDX_COUNT: chan_count = cfg_data[3:0];
          CFG_IDX_GAIN:  gain = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          $display("%0t ns: result with no frame outstanding, actual left %0d right %0d",
                   $time, out_left_out, out_right_out);
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          check_field("left_out", want.left, out_left_out);
          check_field("right_out", want.right, out_right_out);
          check_field("buffer_peak", want.peak, out_buffer_peak);
          check_field("peak_final", want.last, out_peak_final);
        end
      end
      if (in_valid && !in_stall) begin
        expected_frames.push_back(mix_frame({in_chan7_word, in_chan6_word, in_chan5_word,
                                             in_chan4_word, in_chan3_word, in_chan2_word,
                                             in_chan1_word, in_chan0_word}, in_buffer_end));
      end
    end
    pending = expected_frames.size();
    fail_count = mismatches;
  end

endmodule

// File: sim/testbench.sv
// Top of the downmix testbench: clock, reset, stimulus, configuration and verdict.
module testbench;
  import dmx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_SPARE    = 2'd3;
  localparam logic [1:0] CFG_IDX_SPARE = 2'd3;
  localparam int         RANDOM_ITEMS  = 950;
  localparam int         CYCLE_LIMIT   = 200000;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [NUM_CHAN-1:0][WORD_W-1:0] chan_words;
  logic                           in_buffer_end;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [SAMP_W-1:0]       out_left_out;
  logic signed [SAMP_W-1:0]       out_right_out;
  logic [SAMP_W-1:0]              out_buffer_peak;
  logic                           out_peak_final;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [1:0]                     cfg_index;
  logic [15:0]                    cfg_data;
  int                             fail_count;
  int                             pending;
  int                             cycles = 0;
  logic                           idle_on = 1'b1;
  logic [1:0]                     cur_mode = MODE_S16;

  surround_to_stereo_downmix_gain_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_chan0_word(chan_words[0]), .in_chan1_word(chan_words[1]),
    .in_chan2_word(chan_words[2]), .in_chan3_word(chan_words[3]),
    .in_chan4_word(chan_words[4]), .in_chan5_word(chan_words[5]),
    .in_chan6_word(chan_words[6]), .in_chan7_word(chan_words[7]),
    .in_buffer_end(in_buffer_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_left_out(out_left_out), .out_right_out(out_right_out),
    .out_buffer_peak(out_buffer_peak), .out_peak_final(out_peak_final),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  downmix_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_chan0_word(chan_words[0]), .in_chan1_word(chan_words[1]),
    .in_chan2_word(chan_words[2]), .in_chan3_word(chan_words[3]),
    .in_chan4_word(chan_words[4]), .in_chan5_word(chan_words[5]),
    .in_chan6_word(chan_words[6]), .in_chan7_word(chan_words[7]),
    .in_buffer_end(in_buffer_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_left_out(out_left_out), .out_right_out(out_right_out),
    .out_buffer_peak(out_buffer_peak), .out_peak_final(out_peak_final),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) out_stall = idle_on && ($urandom_range(99) < 7);

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == CFG_IDX_MODE) cur_mode = data[1:0];
  endtask

  // Stops the input side and waits until every frame has come back.
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Returns at the falling edge after acceptance with valid still high, so a
  // following frame can go out back to back without valid dropping.
  task automatic push_frame(input logic [NUM_CHAN-1:0][WORD_W-1:0] words, input logic last);
    if (idle_on && $urandom_range(99) < 7) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    chan_words = words;
    in_buffer_end = last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_word(input logic [1:0] mode);
    int              r;
    logic [WORD_W-1:0] w;
    r = $urandom_range(99);
    w = WORD_W'($urandom);
    if (r < 15) begin
      case (mode)
        MODE_U8:  w[7:0] = $urandom_range(1) ? 8'hFF : 8'h00;
        MODE_S24: w[23:8] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        default:  w[15:0] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      endcase
    end else if (r < 30) begin
      // Values next to zero exercise truncation of small negative products.
      case (mode)
        MODE_U8:  w[7:0] = 8'(126 + $urandom_range(4));
        MODE_S24: w[23:8] = 16'($urandom_range(6)) - 16'd3;
        default:  w[15:0] = 16'($urandom_range(6)) - 16'd3;
      endcase
    end else if (r < 36) begin
      w = $urandom_range(1) ? '1 : '0;
    end
    return w;
  endfunction

  task automatic random_setup();
    int          r;
    logic [3:0]  cnt;
    logic [15:0] g;
    if ($urandom_range(1)) write_reg(CFG_IDX_MODE, {14'($urandom), 2'($urandom_range(3))});
    if ($urandom_range(2) != 0) begin
      r = $urandom_range(99);
      if (r < 8) cnt = 4'd0;
      else if (r < 18) cnt = 4'($urandom_range(9, 15));
      else if (r < 60) cnt = 4'($urandom_range(6, 8));
      else cnt = 4'($urandom_range(1, 5));
      write_reg(CFG_IDX_COUNT, {12'($urandom), cnt});
    end
    if ($urandom_range(1)) begin
      r = $urandom_range(99);
      if (r < 10) g = 16'd0;
      else if (r < 20) g = 16'hFFFF;
      else if (r < 40) g = RST_GAIN;
      else if (r < 60) g = 16'($urandom_range(8192));
      else g = 16'($urandom);
      write_reg(CFG_IDX_GAIN, g);
    end
    if ($urandom_range(9) == 0) write_reg(CFG_IDX_SPARE, 16'($urandom));
  endtask

  initial begin
    logic [NUM_CHAN-1:0][WORD_W-1:0] fr;
    int                              sent;
    int                              phase;
    int                              phase_len;
    int                              end_odds;
    rst_n = 1'b0;
    in_valid = 1'b0;
    chan_words = '0;
    in_buffer_end = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_IDX_MODE;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: 16-bit stereo copy at unity gain; unused channels stay out of the peak.
    push_frame('0, 1'b0);
    fr = {NUM_CHAN{24'hFFFFFF}};
    fr[0] = 24'h007FFF;
    fr[1] = 24'h008000;
    push_frame(fr, 1'b0);
    push_frame({NUM_CHAN{24'hFFFFFF}}, 1'b1);
    push_frame('0, 1'b0);

    // 8-bit words, six-channel downmix, largest gain: both saturation limits.
    settle();
    write_reg(CFG_IDX_MODE, {14'd0, MODE_U8});
    write_reg(CFG_IDX_COUNT, 16'd6);
    write_reg(CFG_IDX_GAIN, 16'hFFFF);
    push_frame({NUM_CHAN{24'h0000FF}}, 1'b0);
    push_frame('0, 1'b1);
    push_frame({NUM_CHAN{24'h000080}}, 1'b0);

    // 24-bit words over all eight channels, zero gain.
    settle();
    write_reg(CFG_IDX_MODE, {14'd0, MODE_S24});
    write_reg(CFG_IDX_COUNT, 16'd8);
    write_reg(CFG_IDX_GAIN, 16'd0);
    push_frame({NUM_CHAN{24'hFFFFFF}}, 1'b0);
    push_frame({NUM_CHAN / 2{24'h7FFFFF, 24'h800000}}, 1'b1);
    settle();
    write_reg(CFG_IDX_GAIN, 16'hFFFF);
    fr = '0;
    fr[0] = 24'h7FFF00;
    fr[2] = 24'h800000;
    push_frame(fr, 1'b0);

    // A write beyond the register list changes nothing.
    settle();
    write_reg(CFG_IDX_SPARE, 16'hFFFF);
    push_frame(fr, 1'b1);

    // The spare format code acts as 16-bit; a count of zero acts as mono.
    settle();
    write_reg(CFG_IDX_MODE, {14'h3FFF, MODE_SPARE});
    write_reg(CFG_IDX_COUNT, 16'd0);
    write_reg(CFG_IDX_GAIN, RST_GAIN);
    fr = '0;
    fr[0] = 24'h008000;
    fr[1] = 24'h007FFF;
    push_frame(fr, 1'b0);
    fr[0] = 24'hFF7FFF;
    push_frame(fr, 1'b1);

    // A count above the channel limit is clipped to it.
    settle();
    write_reg(CFG_IDX_MODE, {14'd0, MODE_S16});
    write_reg(CFG_IDX_COUNT, 16'hFFFF);
    push_frame({NUM_CHAN{24'h007FFF}}, 1'b0);
    push_frame({NUM_CHAN{24'h008000}}, 1'b1);

    settle();
    write_reg(CFG_IDX_COUNT, 16'd1);
    fr = '0;
    fr[0] = 24'h001234;
    fr[1] = 24'h007FFF;
    push_frame(fr, 1'b0);
    settle();
    write_reg(CFG_IDX_COUNT, 16'd5);
    fr[4] = 24'h008000;
    push_frame(fr, 1'b1);
    settle();
    write_reg(CFG_IDX_COUNT, 16'd7);
    for (int c = 0; c < NUM_CHAN; c++) fr[c] = pick_word(cur_mode);
    push_frame(fr, 1'b0);

    // Half gain on small negative samples: products truncate toward zero.
    settle();
    write_reg(CFG_IDX_COUNT, 16'd2);
    write_reg(CFG_IDX_GAIN, 16'd2048);
    fr = '0;
    fr[0] = 24'h00FFFF;
    fr[1] = 24'h00FFFD;
    push_frame(fr, 1'b0);
    fr[0] = 24'h00FFFD;
    fr[1] = 24'h00FFFF;
    push_frame(fr, 1'b1);

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      random_setup();
      idle_on = (phase != 2);
      phase_len = (phase == 2) ? 150 : $urandom_range(40, 110);
      if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
      end_odds = $urandom_range(1) ? 4 : 40;
      for (int k = 0; k < phase_len; k++) begin
        for (int c = 0; c < NUM_CHAN; c++) fr[c] = pick_word(cur_mode);
        push_frame(fr, $urandom_range(end_odds - 1) == 0);
        sent++;
      end
      phase++;
    end

    settle();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
